[rtl/core/ssd_pkg.sv]
`timescale 1ns / 1ps

package ssd_pkg;

    // Command codes
    localparam logic [2:0] CMD_DISP_ON  = 3'd0;
    localparam logic [2:0] CMD_DISP_OFF = 3'd1;
    localparam logic [2:0] CMD_SET_DIG  = 3'd2;
    localparam logic [2:0] CMD_SHOW_INT = 3'd3;
    localparam logic [2:0] CMD_SHOW_TEN = 3'd4;

    // Bus bytes
    localparam logic [7:0] MODE_CMD      = 8'h48;
    localparam logic [7:0] MODE_ON_DATA  = 8'h01;
    localparam logic [7:0] MODE_OFF_DATA = 8'h00;
    localparam logic [7:0] ADDR_POS0     = 8'h6a;
    localparam logic [7:0] ADDR_POS1     = 8'h6c;
    localparam logic [7:0] ADDR_POS2     = 8'h6e;
    localparam logic [7:0] ADDR_POS3     = 8'h68;

    // Range limits
    localparam logic [9:0] LIMIT_DIGIT  = 10'd15;
    localparam logic [9:0] LIMIT_INT    = 10'd999;
    localparam logic [9:0] LIMIT_TENTHS = 10'd990;
    localparam logic [9:0] TENTHS_SPLIT = 10'd100;

    // Reciprocal constants: v/10 = (v*205)>>11, v/100 = (v*41)>>12, exact for v < 1024
    localparam logic [7:0] RECIP_10  = 8'd205;
    localparam logic [5:0] RECIP_100 = 6'd41;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One decoded command: up to three frames, or a single error beat
    typedef struct packed {
        logic            err;
        logic [1:0]      nfr;
        logic [2:0][7:0] addr;
        logic [2:0][7:0] data;
    } t_job;

    function automatic logic [7:0] seg_of(input logic [3:0] d, input logic dp);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'h3f;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5b;
            4'h3: s = 8'h4f;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6d;
            4'h6: s = 8'h7d;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7f;
            4'h9: s = 8'h6f;
            4'ha: s = 8'h77;
            4'hb: s = 8'h7c;
            4'hc: s = 8'h39;
            4'hd: s = 8'h5e;
            4'he: s = 8'h79;
            default: s = 8'h71;
        endcase
        // the point table only sets the point on the decimal digits
        if (dp && (d < 4'd10)) begin
            s = s | 8'h80;
        end
        return s;
    endfunction

    function automatic logic [7:0] pos_addr(input logic [1:0] p);
        logic [7:0] a;
        unique case (p)
            2'd0: a = ADDR_POS0;
            2'd1: a = ADDR_POS1;
            2'd2: a = ADDR_POS2;
            default: a = ADDR_POS3;
        endcase
        return a;
    endfunction

endpackage

[rtl/core/ssd_front.sv]
`timescale 1ns / 1ps

module ssd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_command,
    input  logic [9:0]        i_value,
    input  logic [1:0]        i_position,
    input  logic              i_decimal_point,
    output logic              o_push,
    output ssd_pkg::t_job     o_job,
    input  logic              i_q_ready
);
    import ssd_pkg::*;

    logic [17:0] p10;
    logic [15:0] p100;

    logic        r_valid;
    logic [2:0]  r_cmd;
    logic [9:0]  r_v;
    logic [1:0]  r_pos;
    logic        r_dp;
    logic [6:0]  r_q10;
    logic [3:0]  r_h;

    logic        drop;
    logic        adv;
    logic [6:0]  h_x10;
    logic [9:0]  q_x10;
    logic [6:0]  tens_full;
    logic [9:0]  units_full;
    logic [3:0]  tens;
    logic [3:0]  units;
    t_job        job;

    // stage 1: reciprocal multiplies for /10 and /100
    assign p10  = 18'(i_value) * 18'(RECIP_10);
    assign p100 = 16'(i_value) * 16'(RECIP_100);

    assign o_ready = !r_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= i_command;
            r_v   <= i_value;
            r_pos <= i_position;
            r_dp  <= i_decimal_point;
            r_q10 <= p10[17:11];
            r_h   <= p100[15:12];
        end
    end

    // stage 2: remainders by shift-add, then frame selection
    assign h_x10      = {r_h, 3'b000} + 7'({r_h, 1'b0});
    assign q_x10      = 10'({r_q10, 3'b000}) + 10'({r_q10, 1'b0});
    assign tens_full  = r_q10 - h_x10;
    assign units_full = r_v - q_x10;
    assign tens       = tens_full[3:0];
    assign units      = units_full[3:0];

    always_comb begin
        job  = '0;
        drop = 1'b0;
        unique case (r_cmd)
            CMD_DISP_ON: begin
                job.nfr     = 2'd1;
                job.addr[0] = MODE_CMD;
                job.data[0] = MODE_ON_DATA;
            end
            CMD_DISP_OFF: begin
                job.nfr     = 2'd1;
                job.addr[0] = MODE_CMD;
                job.data[0] = MODE_OFF_DATA;
            end
            CMD_SET_DIG: begin
                job.err     = (r_v > LIMIT_DIGIT);
                job.nfr     = 2'd1;
                job.addr[0] = pos_addr(r_pos);
                job.data[0] = seg_of(r_v[3:0], r_dp);
            end
            CMD_SHOW_INT: begin
                job.err     = (r_v > LIMIT_INT);
                job.nfr     = 2'd3;
                job.addr[0] = ADDR_POS0;
                job.data[0] = seg_of(r_h, 1'b0);
                job.addr[1] = ADDR_POS1;
                job.data[1] = seg_of(tens, 1'b0);
                job.addr[2] = ADDR_POS2;
                job.data[2] = seg_of(units, 1'b0);
            end
            CMD_SHOW_TEN: begin
                job.err     = (r_v > LIMIT_TENTHS);
                job.nfr     = 2'd2;
                job.addr[0] = ADDR_POS1;
                job.addr[1] = ADDR_POS2;
                if (r_v < TENTHS_SPLIT) begin
                    // d.d: whole part with the point, then the tenths digit
                    job.data[0] = seg_of(r_q10[3:0], 1'b1);
                    job.data[1] = seg_of(units, 1'b0);
                end else begin
                    // two integer digits, fraction dropped
                    job.data[0] = seg_of(r_h, 1'b0);
                    job.data[1] = seg_of(tens, 1'b0);
                end
            end
            default: begin
                drop = 1'b1;
            end
        endcase
    end

    assign adv    = r_valid && (drop || i_q_ready);
    assign o_push = r_valid && !drop && i_q_ready;
    assign o_job  = job;

endmodule

[rtl/core/ssd_fifo.sv]
`timescale 1ns / 1ps

module ssd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ssd_pkg::t_job     i_job,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output ssd_pkg::t_job     o_job
);
    import ssd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_ready = (r_cnt != CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

[rtl/core/ssd_back.sv]
`timescale 1ns / 1ps

module ssd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ssd_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_bus_byte,
    output logic              o_frame_start,
    output logic              o_frame_end,
    output logic              o_byte_valid,
    output logic              o_status,
    output logic              o_last
);
    import ssd_pkg::*;

    logic        r_busy;
    t_job        r_job;
    logic [2:0]  r_idx;

    logic [1:0]  frm;
    logic        second;
    logic        beat_last;
    logic        load;
    logic [7:0]  beat_byte;

    // current beat from the job and the beat index
    assign frm       = r_idx[2:1];
    assign second    = r_idx[0];
    assign beat_last = r_job.err || (second && (frm == r_job.nfr - 2'd1));
    assign beat_byte = second ? r_job.data[frm] : r_job.addr[frm];
    assign load      = r_busy && (!o_valid || i_ready);
    assign o_pop     = i_q_valid && (!r_busy || (load && beat_last));

    // job sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (load) begin
            if (beat_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_job.err) begin
                o_bus_byte    <= '0;
                o_frame_start <= 1'b0;
                o_frame_end   <= 1'b0;
                o_byte_valid  <= 1'b0;
                o_status      <= 1'b1;
                o_last        <= 1'b1;
            end else begin
                o_bus_byte    <= beat_byte;
                o_frame_start <= !second;
                o_frame_end   <= second;
                o_byte_valid  <= 1'b1;
                o_status      <= 1'b0;
                o_last        <= beat_last;
            end
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_job.err |-> r_idx < {r_job.nfr, 1'b0})
        else $error("beat index past end of job");
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last && !o_byte_valid && !o_frame_start)
        else $error("error beat malformed");
    a_frame_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid |-> (o_frame_start != o_frame_end))
        else $error("beat both or neither start and stop");
    a_last_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid && o_last |-> o_frame_end)
        else $error("last beat does not close a frame");
`endif

endmodule

[rtl/core/seven_segment_display_writer.sv]
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     i_valid / o_ready     i_command, i_value, i_position, i_decimal_point
// output    o_valid / i_ready     o_bus_byte, o_frame_start, o_frame_end,
//                                 o_byte_valid, o_status, o_last
//
// One output beat per cycle from the back end while i_ready is high and jobs are
// queued; a command gives 2, 4 or 6 beats, one error beat, or none for unknown codes.
// The first output beat passes through the front register, queue, sequencer and
// output register. The back end's beat sequencer sets the rate.
// Reset is synchronous, active low, and clears valids, queue pointers and sequencer.
// Input and output stall independently through the two-entry job queue.

module seven_segment_display_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [9:0]  i_value,
    input  logic [1:0]  i_position,
    input  logic        i_decimal_point,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_bus_byte,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic        o_byte_valid,
    output logic        o_status,
    output logic        o_last
);
    import ssd_pkg::*;

    logic  push;
    logic  q_ready;
    logic  q_valid;
    logic  pop;
    t_job  push_job;
    t_job  head_job;

    ssd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_value         (i_value),
        .i_position      (i_position),
        .i_decimal_point (i_decimal_point),
        .o_push          (push),
        .o_job           (push_job),
        .i_q_ready       (q_ready)
    );

    ssd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    ssd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bus_byte    (o_bus_byte),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_byte_valid  (o_byte_valid),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule
